/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");

`endif

/* sv/slist_pkg.sv */
// Types and constants of the sorted list engine.
package slist_pkg;
   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int IDX_W      = $clog2(CAPACITY);

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_DELETE = 3'd1;
   localparam logic [2:0] OP_FIND   = 3'd2;
   localparam logic [2:0] OP_CLEAR  = 3'd3;
   localparam logic [2:0] OP_REWIND = 3'd4;
   localparam logic [2:0] OP_READ   = 3'd5;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_FULL        = 2'd1;
   localparam logic [1:0] ST_NOT_PRESENT = 2'd2;
   localparam logic [1:0] ST_PAST_END    = 2'd3;

   typedef struct packed {
      logic                  ins_go;
      logic                  del_go;
      logic [DATA_WIDTH-1:0] value;
   } cell_ctl_type;
endpackage

/* sv/slist_cell.sv */
// One list cell: holds an entry, compares it to the operand, shifts with its neighbors.
module slist_cell import slist_pkg::*; (
   input  logic                  clock,
   input  cell_ctl_type          ctl,
   input  logic                  del_en,
   input  logic                  occ,
   input  logic                  prev_lt,
   input  logic [DATA_WIDTH-1:0] prev_entry,
   input  logic [DATA_WIDTH-1:0] next_entry,
   output logic                  lt,
   output logic                  hit,
   output logic [DATA_WIDTH-1:0] entry
);
   logic [DATA_WIDTH-1:0] entry_ff, entry_in;
   logic                  at_loc;

   assign lt     = occ & (entry_ff < ctl.value);
   assign at_loc = !lt & prev_lt;
   assign hit    = occ & at_loc & (entry_ff == ctl.value);
   assign entry  = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctl.ins_go && !lt) begin
         entry_in = at_loc ? ctl.value : prev_entry;
      end else if (del_en && !lt) begin
         entry_in = next_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end
endmodule

/* sv/slist_chain.sv */
// Row of list cells with hit reduction and cursor read port.
module slist_chain import slist_pkg::*; (
   input  logic                  clock,
   input  cell_ctl_type          ctl,
   input  logic [CNT_W-1:0]      count,
   input  logic [IDX_W-1:0]      rd_idx,
   output logic                  found,
   output logic [DATA_WIDTH-1:0] rd_data
);
   logic [CAPACITY-1:0]   lt, hit, occ;
   logic [DATA_WIDTH-1:0] entry [CAPACITY];
   logic                  del_en;

   // delete shifts only when some cell holds an equal entry
   assign del_en = ctl.del_go & found;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                  p_lt;
      logic [DATA_WIDTH-1:0] p_entry, n_entry;

      assign occ[i] = CNT_W'(i) < count;

      if (i == 0) begin : g_head
         assign p_lt    = 1'b1;
         assign p_entry = entry[i];
      end else begin : g_body
         assign p_lt    = lt[i-1];
         assign p_entry = entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign n_entry = entry[i];
      end else begin : g_mid
         assign n_entry = entry[i+1];
      end

      slist_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .del_en     (del_en),
         .occ        (occ[i]),
         .prev_lt    (p_lt),
         .prev_entry (p_entry),
         .next_entry (n_entry),
         .lt         (lt[i]),
         .hit        (hit[i]),
         .entry      (entry[i])
      );
   end

   assign found   = |hit;
   assign rd_data = entry[rd_idx];
endmodule

/* sv/sorted_list_engine.sv */
// Sorted list engine top level: command decode, count, cursor and result word register.
// A result word is registered and valid in the cycle after its request word is accepted.
// Throughput: one request word per cycle unless stalled; the cell chain compares and shifts.
// Reset clears the count, the read cursor and the result valid flag.
// Entry storage is not cleared; only entries below the count are ever read.
module sorted_list_engine import slist_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [31:0] rsp_item_out,
   output logic [4:0]  rsp_count,
   output logic        rsp_full_res,
   output logic [1:0]  rsp_status
);
   logic                  accept;
   logic [DATA_WIDTH-1:0] value;
   logic                  found, rd_ok, not_full;
   logic [DATA_WIDTH-1:0] rd_data;
   cell_ctl_type          ctl;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cursor_ff, cursor_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             found_ff, found_in;
   logic [31:0]      item_ff, item_in;
   logic [1:0]       status_ff, status_in;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & !req_stall;
   assign value     = req_value[DATA_WIDTH-1:0];
   assign not_full  = count_ff < CNT_W'(CAPACITY);
   assign rd_ok     = cursor_ff < count_ff;

   assign ctl.value  = value;
   assign ctl.ins_go = accept & (req_op == OP_INSERT) & not_full;
   assign ctl.del_go = accept & (req_op == OP_DELETE);

   slist_chain u_chain (
      .clock   (clock),
      .ctl     (ctl),
      .count   (count_ff),
      .rd_idx  (cursor_ff[IDX_W-1:0]),
      .found   (found),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in  = count_ff;
      cursor_in = cursor_ff;
      found_in  = 1'b0;
      item_in   = '0;
      status_in = ST_OK;
      unique case (req_op)
         OP_INSERT: begin
            if (not_full) count_in = count_ff + CNT_W'(1);
            else status_in = ST_FULL;
         end
         OP_DELETE: begin
            found_in = found;
            if (found) count_in = count_ff - CNT_W'(1);
            else status_in = ST_NOT_PRESENT;
         end
         OP_FIND: begin
            found_in = found;
            if (!found) status_in = ST_NOT_PRESENT;
         end
         OP_CLEAR:  count_in = '0;
         OP_REWIND: cursor_in = '0;
         OP_READ: begin
            if (rd_ok) begin
               item_in   = 32'(rd_data);
               cursor_in = cursor_ff + CNT_W'(1);
            end else begin
               status_in = ST_PAST_END;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff  <= count_in;
            cursor_ff <= cursor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         found_ff  <= found_in;
         item_ff   <= item_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = found_ff;
   assign rsp_item_out = item_ff;
   assign rsp_count    = count_ff;
   assign rsp_full_res = count_ff == CNT_W'(CAPACITY);
   assign rsp_status   = status_ff;
endmodule

/* sv/slist_checker.sv */
// Port-level checker for the sorted list engine, bound to the top level.
`include "assert_macros.svh"

module slist_checker import slist_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_found,
   input logic [31:0] rsp_item_out,
   input logic [4:0]  rsp_count,
   input logic        rsp_full_res,
   input logic [1:0]  rsp_status
);
   `ASSERT_NEXT(a_accept_gives_word, clock, reset, req_valid && !req_stall, rsp_valid)
   `ASSERT_NEXT(a_held_word, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_count) && $stable(rsp_status) && $stable(rsp_item_out))
   `ASSERT_IMPLY(a_full_flag, clock, reset, rsp_valid, rsp_full_res == (rsp_count == 5'(CAPACITY)))
   `ASSERT_IMPLY(a_reject_full, clock, reset, rsp_valid && rsp_status == ST_FULL,
      rsp_full_res && !rsp_found && rsp_item_out == '0)
   `ASSERT_IMPLY(a_found_ok, clock, reset, rsp_valid && rsp_found, rsp_status == ST_OK)
endmodule

bind sorted_list_engine slist_checker u_slist_checker (.*);
